[src/hgfd_pkg.sv]
// Shared types and constants for the height gradient flow direction block.
`timescale 1ns / 1ps

package hgfd_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 33;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FLAT_LIMIT   = 2'd2
  } hgfd_reg_t;

  localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd1024;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd1024;
  localparam logic [32:0] FLAT_LIMIT_RESET   = 33'd171;

  typedef struct packed {
    logic [15:0] height_sample;
    logic        frame_start;
  } hgfd_in_t;

  typedef struct packed {
    logic [11:0]        center_col;
    logic [15:0]        center_row;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic               is_flat;
    logic               last_in_frame;
  } hgfd_out_t;

  typedef struct packed {
    logic [11:0] col;
    logic [15:0] row;
    logic        last;
    logic        flat;
    logic [1:0]  neg;
    logic [1:0]  zero;
  } hgfd_meta_t;

endpackage

[src/hgfd_if.sv]
// Valid/ready stream interfaces for height samples and direction results.
`timescale 1ns / 1ps

interface hgfd_in_if;
  import hgfd_pkg::*;
  logic     valid;
  logic     ready;
  hgfd_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hgfd_out_if;
  import hgfd_pkg::*;
  logic      valid;
  logic      ready;
  hgfd_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/height_gradient_flow_direction.sv]
// Top level: streaming downhill direction of a height map, one pixel per clock when the output side keeps up.
`timescale 1ns / 1ps

// One height sample is taken per clock in raster order and one result leaves per interior
// pixel, so the block runs at one sample per cycle when the output side keeps up. A single
// line store of MAX_WIDTH words holds the two previous rows; it is read and rewritten at the
// column of each sample. A sample passes the line store read, the difference, square and
// sum registers, then the normalization, which finds one bit of each direction component
// per stage with shift-and-add updates, and last the output register. A stall on the
// result side holds the whole pipeline and drops ready on the sample side.
module height_gradient_flow_direction #(
  parameter int MAX_WIDTH     = 4096,
  parameter int SAMPLE_BITS   = 16,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  hgfd_in_if.sink                            samples,
  hgfd_out_if.source                         results,
  input  logic                               cfg_we,
  input  logic [hgfd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hgfd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import hgfd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int F  = DIR_FRAC_BITS;
  localparam int ADDR_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int CW = (WB > 13) ? WB : 13;
  localparam int SW = 2 * SB + 1;
  localparam int AW = 2 * SB + 2 * F + 6;
  localparam int NS = F + 2;

  logic [12:0] frame_width;
  logic [15:0] frame_height;
  logic [32:0] flat_limit_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RESET;
      frame_height  <= FRAME_HEIGHT_RESET;
      flat_limit_sq <= FLAT_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (hgfd_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width   <= cfg_data[12:0];
        REG_FRAME_HEIGHT: frame_height  <= cfg_data[15:0];
        REG_FLAT_LIMIT:   flat_limit_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;

  always_comb begin
    if (CW'(frame_width) < CW'(3)) begin
      w_eff = CW'(3);
    end else if (CW'(frame_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width);
    end
    h_eff = (frame_height < 16'd3) ? 16'd3 : frame_height;
  end

  logic en;
  logic take;
  logic out_v;
  hgfd_out_t out_payload;

  assign en = !out_v || results.ready;
  assign samples.ready = en;
  assign take = samples.valid && en;
  assign results.valid = out_v;
  assign results.payload = out_payload;

  // Position tracking for the incoming sample.
  logic [ADDR_BITS-1:0] col_pos, col_pos_next;
  logic [15:0]          row_pos, row_pos_next;
  logic [ADDR_BITS-1:0] x0;
  logic [15:0]          y0;
  logic [ADDR_BITS:0]   x_inc;
  logic [16:0]          y_inc;
  logic                 emit0, last0;
  logic [SB-1:0]        sample0;

  always_comb begin
    x0 = samples.payload.frame_start ? '0 : col_pos;
    y0 = samples.payload.frame_start ? '0 : row_pos;
    sample0 = SB'(samples.payload.height_sample);
    x_inc = {1'b0, x0} + (ADDR_BITS+1)'(1);
    y_inc = {1'b0, y0} + 17'd1;
    emit0 = (x0 >= ADDR_BITS'(2)) && (CW'(x0) < w_eff) && (y0 >= 16'd2) && (y0 < h_eff);
    last0 = (CW'(x_inc) == w_eff) && (y_inc == {1'b0, h_eff});
    if (CW'(x_inc) >= w_eff) begin
      col_pos_next = '0;
      row_pos_next = (y_inc >= {1'b0, h_eff}) ? 16'd0 : y_inc[15:0];
    end else begin
      col_pos_next = x_inc[ADDR_BITS-1:0];
      row_pos_next = y0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (take) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // Line store: each word holds the older row above the newer row at one column.
  logic [2*SB-1:0]      line_mem [MAX_WIDTH];
  logic [2*SB-1:0]      mem_rd;
  logic                 s1_v;
  logic [ADDR_BITS-1:0] s1_addr;
  logic [SB-1:0]        s1_sample;
  logic                 s1_emit, s1_last;
  logic [11:0]          s1_col;
  logic [15:0]          s1_row;
  logic                 s1_fwd;
  logic [2*SB-1:0]      s1_fwd_word;
  logic [2*SB-1:0]      rd_word;
  logic [SB-1:0]        older, newer;
  logic [2*SB-1:0]      wr_word;

  assign rd_word = s1_fwd ? s1_fwd_word : mem_rd;
  assign older = rd_word[2*SB-1:SB];
  assign newer = rd_word[SB-1:0];
  assign wr_word = {newer, s1_sample};

  always_ff @(posedge clk) begin
    if (s1_v && en) begin
      line_mem[s1_addr] <= wr_word;
    end
    if (take) begin
      mem_rd <= line_mem[x0];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr     <= x0;
      s1_sample   <= sample0;
      s1_emit     <= emit0;
      s1_last     <= last0;
      s1_col      <= 12'(x0 - ADDR_BITS'(1));
      s1_row      <= y0 - 16'd1;
      s1_fwd      <= s1_v && (s1_addr == x0);
      s1_fwd_word <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= samples.valid;
    end
  end

  // Window columns that the differences need.
  logic [SB-1:0] win11, win12, win02, win22;
  logic                 s2_v;
  logic signed [SB:0]   s2_dx, s2_dy;
  hgfd_meta_t           s2_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      win11 <= '0;
      win12 <= '0;
      win02 <= '0;
      win22 <= '0;
      s2_v  <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v && s1_emit;
      if (s1_v) begin
        win11 <= win12;
        win12 <= newer;
        win02 <= older;
        win22 <= s1_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx <= $signed({1'b0, newer}) - $signed({1'b0, win11});
      s2_dy <= $signed({1'b0, win22}) - $signed({1'b0, win02});
      s2_meta.col  <= s1_col;
      s2_meta.row  <= s1_row;
      s2_meta.last <= s1_last;
      s2_meta.flat <= 1'b0;
      s2_meta.neg  <= '0;
      s2_meta.zero <= '0;
    end
  end

  logic               s3_v;
  logic [2*SB-1:0]    s3_dx2, s3_dy2;
  hgfd_meta_t         s3_meta;
  logic signed [2*SB+1:0] sq_x, sq_y;

  assign sq_x = s2_dx * s2_dx;
  assign sq_y = s2_dy * s2_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dx2 <= sq_x[2*SB-1:0];
      s3_dy2 <= sq_y[2*SB-1:0];
      s3_meta.col  <= s2_meta.col;
      s3_meta.row  <= s2_meta.row;
      s3_meta.last <= s2_meta.last;
      s3_meta.flat <= s2_meta.flat;
      s3_meta.neg  <= {s2_dy > 0, s2_dx > 0};
      s3_meta.zero <= {s2_dy == 0, s2_dx == 0};
    end
  end

  // Normalization: per component, the largest m with (2m-1)^2 * s <= 4 * d^2 * 2^(2F).
  // a = (2m-1)^2 * s and b = (2m-1) * s are kept so each trial bit needs only shifts and adds.
  logic                  sr_v    [NS];
  hgfd_meta_t            sr_meta [NS];
  logic [SW-1:0]         sr_s    [NS];
  logic signed [AW-1:0]  sr_a    [NS][2];
  logic signed [AW-1:0]  sr_b    [NS][2];
  logic signed [AW-1:0]  sr_t    [NS][2];
  logic [F:0]            sr_m    [NS][2];
  logic [SW-1:0]         sum_s;

  assign sum_s = SW'(s3_dx2) + SW'(s3_dy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      sr_v[0] <= 1'b0;
    end else if (en) begin
      sr_v[0] <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr_meta[0].col  <= s3_meta.col;
      sr_meta[0].row  <= s3_meta.row;
      sr_meta[0].last <= s3_meta.last;
      sr_meta[0].flat <= ({{33{1'b0}}, sum_s} <= {{SW{1'b0}}, flat_limit_sq});
      sr_meta[0].neg  <= s3_meta.neg;
      sr_meta[0].zero <= s3_meta.zero;
      sr_s[0]         <= sum_s;
      sr_a[0][0]      <= $signed(AW'(sum_s));
      sr_a[0][1]      <= $signed(AW'(sum_s));
      sr_b[0][0]      <= -$signed(AW'(sum_s));
      sr_b[0][1]      <= -$signed(AW'(sum_s));
      sr_t[0][0]      <= $signed(AW'(s3_dx2)) <<< (2 * F + 2);
      sr_t[0][1]      <= $signed(AW'(s3_dy2)) <<< (2 * F + 2);
      sr_m[0][0]      <= '0;
      sr_m[0][1]      <= '0;
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_search
    localparam int BIT = F - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[k+1] <= 1'b0;
      end else if (en) begin
        sr_v[k+1] <= sr_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_meta[k+1] <= sr_meta[k];
        sr_s[k+1]    <= sr_s[k];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [AW-1:0] a_try, b_try;
      logic                 fits;

      always_comb begin
        a_try = sr_a[k][l] + (sr_b[k][l] <<< (BIT + 2))
              + ($signed(AW'(sr_s[k])) <<< (2 * BIT + 2));
        b_try = sr_b[k][l] + ($signed(AW'(sr_s[k])) <<< (BIT + 1));
        fits  = a_try <= sr_t[k][l];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sr_t[k+1][l] <= sr_t[k][l];
          sr_a[k+1][l] <= fits ? a_try : sr_a[k][l];
          sr_b[k+1][l] <= fits ? b_try : sr_b[k][l];
          sr_m[k+1][l] <= sr_m[k][l] | ((F+1)'(fits) << BIT);
        end
      end
    end
  end

  logic signed [15:0] mag_x, mag_y, fx, fy;
  hgfd_meta_t         fm;

  always_comb begin
    fm    = sr_meta[NS-1];
    mag_x = 16'(sr_m[NS-1][0]);
    mag_y = 16'(sr_m[NS-1][1]);
    fx = (fm.flat || fm.zero[0]) ? 16'sd0 : (fm.neg[0] ? -mag_x : mag_x);
    fy = (fm.flat || fm.zero[1]) ? 16'sd0 : (fm.neg[1] ? -mag_y : mag_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= sr_v[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_payload.center_col    <= fm.col;
      out_payload.center_row    <= fm.row;
      out_payload.flow_x        <= fx;
      out_payload.flow_y        <= fy;
      out_payload.is_flat       <= fm.flat;
      out_payload.last_in_frame <= fm.last;
    end
  end

endmodule

[tb/height_gradient_flow_direction_tb.sv]
// Testbench for the height gradient flow direction block: directed frames, random frames, checks.
`timescale 1ns / 1ps

module height_gradient_flow_direction_tb;
  import hgfd_pkg::*;

  localparam int LINE_WORDS = 4096;
  localparam int FRAC_BITS  = 14;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    bit [0:8][15:0] px;
    bit             fs;
    hgfd_out_t      res;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  hgfd_in_if  sample_bus ();
  hgfd_out_if result_bus ();

  height_gradient_flow_direction DUT (
    .clk(clk),
    .rst(rst),
    .samples(sample_bus.sink),
    .results(result_bus.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  bit [15:0]   line_older [LINE_WORDS];
  bit [15:0]   line_newer [LINE_WORDS];
  bit [15:0]   win [3][3];
  int unsigned col_pos, row_pos;
  bit [12:0]   width_reg;
  bit [15:0]   height_reg;
  bit [32:0]   flat_reg;

  hgfd_out_t   pending_dirs [$];
  int          errors;
  int          results_seen;
  int          items_sent;
  int          send_idle;
  int          recv_idle;
  int unsigned cycles;
  frame_row_t  frames [3];

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic bit round_ok(longint unsigned m, longint unsigned d2, longint unsigned s);
    bit [127:0] lhs, rhs;
    if (m == 0) return 1'b1;
    lhs = 128'(2 * m - 1) * 128'(2 * m - 1) * 128'(s);
    rhs = (128'(d2) * 4) << (2 * FRAC_BITS);
    return lhs <= rhs;
  endfunction

  function automatic longint unsigned unit_length_mag(longint unsigned d2, longint unsigned s);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 1 << FRAC_BITS;
    if (s == 0) return 0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (round_ok(mid, d2, s)) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [15:0] downhill(longint d, longint unsigned mag);
    if (d == 0) return '0;
    return d > 0 ? -16'(mag) : 16'(mag);
  endfunction

  function automatic bit predict_direction(hgfd_in_t item, output hgfd_out_t res);
    int unsigned w, h, x, y;
    longint dx, dy;
    longint unsigned dx2, dy2, s;
    bit flat;
    w = width_reg;
    h = height_reg;
    if (w < 3) w = 3;
    if (w > LINE_WORDS) w = LINE_WORDS;
    if (h < 3) h = 3;
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = col_pos;
    y = row_pos;
    if (x >= LINE_WORDS) x = LINE_WORDS - 1;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_older[x];
    win[1][2] = line_newer[x];
    win[2][2] = item.height_sample;
    line_older[x] = line_newer[x];
    line_newer[x] = item.height_sample;
    res = '0;
    predict_direction = 1'b0;
    if (x >= 2 && x < w && y >= 2 && y < h) begin
      dx = longint'(win[1][2]) - longint'(win[1][0]);
      dy = longint'(win[2][1]) - longint'(win[0][1]);
      dx2 = dx * dx;
      dy2 = dy * dy;
      s = dx2 + dy2;
      flat = s <= flat_reg;
      res.center_col = 12'(x - 1);
      res.center_row = 16'(y - 1);
      res.flow_x = flat ? '0 : downhill(dx, unit_length_mag(dx2, s));
      res.flow_y = flat ? '0 : downhill(dy, unit_length_mag(dy2, s));
      res.is_flat = flat;
      res.last_in_frame = (x == w - 1 && y == h - 1);
      predict_direction = 1'b1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endfunction

  // Sends one sample; the predictor runs at the edge of its transfer.
  task automatic send_sample(bit [15:0] height, bit fs, bit use_typed, hgfd_out_t typed);
    hgfd_in_t  item;
    hgfd_out_t res;
    item.height_sample = height;
    item.frame_start = fs;
    while ($urandom_range(99) < send_idle) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.payload <= item;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    items_sent++;
    if (predict_direction(item, res)) begin
      pending_dirs.insert(pending_dirs.size(), use_typed ? typed : res);
    end
  endtask

  task automatic write_reg(hgfd_reg_t idx, bit [32:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = value[12:0];
      REG_FRAME_HEIGHT: height_reg = value[15:0];
      default:          flat_reg = value;
    endcase
  endtask

  task automatic settle_and_configure(bit [12:0] w, bit [15:0] h, bit [32:0] lim);
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(REG_FRAME_WIDTH, 33'(w));
    write_reg(REG_FRAME_HEIGHT, 33'(h));
    write_reg(REG_FLAT_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic run_frames(bit [12:0] w, bit [15:0] h, bit [32:0] lim, int n);
    bit [15:0] height;
    bit fs;
    height = 16'($urandom);
    settle_and_configure(w, h, lim);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       height = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        1, 2:    height = height + 16'($urandom_range(30)) - 16'd15;
        default: height = 16'($urandom);
      endcase
      fs = (i == 0) || ($urandom_range(59) == 0);
      send_sample(height, fs, 1'b0, '0);
    end
  endtask

  initial begin
    frames[0] = '{px: '{default: 16'd0}, fs: 1'b1,
                  res: '{center_col: 12'd1, center_row: 16'd1, flow_x: 16'sd0,
                         flow_y: 16'sd0, is_flat: 1'b1, last_in_frame: 1'b1}};
    frames[1] = '{px: {16'd0, 16'd0, 16'd0, 16'd0, 16'd40000, 16'd65535,
                       16'd0, 16'd0, 16'd0}, fs: 1'b0,
                  res: '{center_col: 12'd1, center_row: 16'd1, flow_x: -16'sd16384,
                         flow_y: 16'sd0, is_flat: 1'b0, last_in_frame: 1'b1}};
    frames[2] = '{px: {16'd0, 16'd1000, 16'd0, 16'd1000, 16'd65535, 16'd0,
                       16'd0, 16'd0, 16'd0}, fs: 1'b0,
                  res: '{center_col: 12'd1, center_row: 16'd1, flow_x: 16'sd11585,
                         flow_y: 16'sd11585, is_flat: 1'b0, last_in_frame: 1'b1}};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.payload = '0;
    result_bus.ready = 1'b0;
    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    flat_reg = FLAT_LIMIT_RESET;
    send_idle = 29;
    recv_idle = 64;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Three 3x3 frames; the second and third begin by the wrap at frame end.
    settle_and_configure(13'd3, 16'd3, FLAT_LIMIT_RESET);
    foreach (frames[f]) begin
      for (int k = 0; k < 9; k++) begin
        send_sample(frames[f].px[k], frames[f].fs && k == 0, k == 8, frames[f].res);
      end
    end

    run_frames(13'($urandom_range(3, 9)), 16'($urandom_range(3, 6)), 33'd171, 60);
    run_frames(13'($urandom_range(3, 9)), 16'($urandom_range(3, 6)), 33'd0, 60);
    send_idle = 64;
    recv_idle = 29;
    run_frames(13'($urandom_range(3, 9)), 16'($urandom_range(3, 6)),
               33'($urandom_range(5000)), 60);
    run_frames(13'($urandom_range(3, 9)), 16'($urandom_range(3, 6)), 33'h1_FFFF_FFFF, 60);
    send_idle = 0;
    recv_idle = 0;
    run_frames(13'($urandom_range(3, 12)), 16'($urandom_range(3, 8)), 33'd171, 60);
    run_frames(13'd0, 16'd0, 33'd171, 30);
    run_frames(13'd8191, 16'd2, 33'd171, 40);
    run_frames(13'd1, 16'd65535, 33'd1000, 40);

    sample_bus.valid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d height samples and checked %0d direction results.", items_sent,
             results_seen);
    $display("Covered clamped sizes, zero and full flat limits, and both idling patterns.");
    if (errors == 0 && pending_dirs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    hgfd_out_t want, got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = result_bus.payload;
      if (pending_dirs.size() == 0) begin
        $display("unexpected result at column %0d row %0d", got.center_col, got.center_row);
        errors++;
      end else begin
        want = pending_dirs.pop_front();
        if (got.center_col !== want.center_col) report("center_col", got.center_col,
                                                       want.center_col);
        if (got.center_row !== want.center_row) report("center_row", got.center_row,
                                                       want.center_row);
        if (got.flow_x !== want.flow_x) report("flow_x", got.flow_x, want.flow_x);
        if (got.flow_y !== want.flow_y) report("flow_y", got.flow_y, want.flow_y);
        if (got.is_flat !== want.is_flat) report("is_flat", got.is_flat, want.is_flat);
        if (got.last_in_frame !== want.last_in_frame) report("last_in_frame",
                                                             got.last_in_frame,
                                                             want.last_in_frame);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
